// ===== rtl/isfp_pkg.sv =====
// shared types and constants of the i/o sample frame parser
package isfp_pkg;

  // most analog readings taken from one frame (1..4, one per channel of ChanW bits)
  localparam int unsigned MaxAnalog = 4;

  // millivolt scaling: (raw * MvScale) >> MvShift
  localparam int unsigned MvScale = 1200;
  localparam int unsigned MvShift = 10;

  localparam int unsigned RawW   = 16;
  localparam int unsigned ValueW = 17;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned ProdW  = RawW + $clog2(MvScale + 1);

  // largest analog value in millivolts
  localparam int unsigned MaxMillivolts = ((2 ** RawW - 1) * MvScale) >> MvShift;

  // depth of the request queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic {
    KIND_DIGITAL = 1'b0,
    KIND_ANALOG  = 1'b1
  } kind_e;

  // one classified request handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [ChanW-1:0]  channel;
    logic [RawW-1:0]   raw;
    logic              last;
  } cmd_t;

endpackage

// ===== rtl/isfp_front.sv =====
// front end: walks the frame bytes and classifies them into requests
module isfp_front import isfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_start_i,
  output logic       enq_o,
  output cmd_t       cmd_o,
  output logic       in_frame_o
);

  localparam logic [4:0] PosMaskHi       = 5'd1;
  localparam logic [4:0] PosMaskLo       = 5'd2;
  localparam logic [4:0] PosAnalogMask   = 5'd3;
  localparam logic [4:0] PosDigHi        = 5'd4;
  localparam logic [4:0] PosDigLo        = 5'd5;
  localparam logic [4:0] AnalogBaseDig   = 5'd6;
  localparam logic [4:0] AnalogBaseNoDig = 5'd4;
  localparam logic [3:0] MaxAnalogW      = 4'(MaxAnalog);

  function automatic logic [3:0] count_ones(logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  logic       in_frame_q, in_frame_d;
  logic [4:0] pos_q, pos_d;
  logic       dig_q, dig_d;
  logic [3:0] acount_q, acount_d;
  logic [2:0] slot_q, slot_d;
  logic [7:0] held_q, held_d;

  logic [3:0] eff;
  logic [4:0] base;
  logic [4:0] offset;
  logic [3:0] slot_inc;
  logic [3:0] ones;

  assign eff      = (acount_q < MaxAnalogW) ? acount_q : MaxAnalogW;
  assign base     = dig_q ? AnalogBaseDig : AnalogBaseNoDig;
  assign offset   = pos_q - base;
  assign slot_inc = {1'b0, slot_q} + 4'd1;
  assign ones     = count_ones(frame_byte_i);

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    dig_d      = dig_q;
    acount_d   = acount_q;
    slot_d     = slot_q;
    held_d     = held_q;
    enq_o      = 1'b0;
    cmd_o      = '{kind: KIND_DIGITAL, channel: '0, raw: '0, last: 1'b0};

    if (accept_i) begin
      if (frame_start_i) begin
        in_frame_d = 1'b1;
        pos_d      = PosMaskHi;
        dig_d      = 1'b0;
        acount_d   = '0;
        slot_d     = '0;
        held_d     = '0;
      end else if (in_frame_q) begin
        pos_d = pos_q + 5'd1;
        if (pos_q == PosMaskHi || pos_q == PosMaskLo) begin
          if (frame_byte_i != 8'd0) begin
            dig_d = 1'b1;
          end
        end else if (pos_q == PosAnalogMask) begin
          acount_d = ones;
          // nothing enabled at all: frame is over
          if (!dig_q && ones == 4'd0) begin
            in_frame_d = 1'b0;
          end
        end else if (dig_q && pos_q == PosDigHi) begin
          held_d = frame_byte_i;
        end else if (dig_q && pos_q == PosDigLo) begin
          enq_o      = 1'b1;
          cmd_o.kind = KIND_DIGITAL;
          cmd_o.raw  = {held_q, frame_byte_i};
          cmd_o.last = (eff == 4'd0);
          if (eff == 4'd0) begin
            in_frame_d = 1'b0;
          end
        end else if (pos_q < base || {1'b0, slot_q} >= eff) begin
          // malformed position, drop the frame
          in_frame_d = 1'b0;
        end else if (!offset[0]) begin
          held_d = frame_byte_i;
        end else begin
          enq_o         = 1'b1;
          cmd_o.kind    = KIND_ANALOG;
          cmd_o.channel = slot_q[ChanW-1:0];
          cmd_o.raw     = {held_q, frame_byte_i};
          cmd_o.last    = (slot_inc >= eff);
          slot_d        = slot_inc[2:0];
          if (slot_inc >= eff) begin
            in_frame_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      dig_q      <= 1'b0;
      acount_q   <= '0;
      slot_q     <= '0;
      held_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      dig_q      <= dig_d;
      acount_q   <= acount_d;
      slot_q     <= slot_d;
      held_q     <= held_d;
    end
  end

  assign in_frame_o = in_frame_q;

endmodule

// ===== rtl/isfp_cmd_queue.sv =====
// small request queue between the front and back ends
module isfp_cmd_queue import isfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_cmd_o,
  output logic empty_o
);

  localparam logic [QPtrW-1:0] LastPtr = QPtrW'(QueueDepth - 1);
  localparam logic [QCntW-1:0] FullCnt = QCntW'(QueueDepth);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign rd_cmd_o = mem_q[rd_ptr_q];
  assign full_o   = (cnt_q == FullCnt);
  assign empty_o  = (cnt_q == '0);

endmodule

// ===== rtl/isfp_back.sv =====
// back end: scales analog readings and holds the result register
module isfp_back import isfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_take_o,
  output logic              res_valid_o,
  input  logic              res_pop_i,
  output logic              kind_o,
  output logic [ChanW-1:0]  channel_o,
  output logic [ValueW-1:0] value_o,
  output logic              last_o
);

  logic              valid_q;
  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] value_d;
  logic [ValueW-1:0] value_q;
  kind_e             kind_q;
  logic [ChanW-1:0]  chan_q;
  logic              last_q;

  assign prod    = ProdW'(cmd_i.raw) * ProdW'(MvScale);
  assign value_d = (cmd_i.kind == KIND_ANALOG) ? prod[MvShift +: ValueW]
                                                : ValueW'(cmd_i.raw);

  // load whenever the result register is free or being drained
  assign cmd_take_o = cmd_valid_i && (!valid_q || res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      valid_q <= 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      value_q <= value_d;
      kind_q  <= cmd_i.kind;
      chan_q  <= cmd_i.channel;
      last_q  <= cmd_i.last;
    end
  end

  assign res_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign channel_o   = chan_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/io_sample_frame_parser.sv =====
// top level of the i/o sample frame parser
// a byte that completes a reading is written into the request queue at the edge that takes
//   it; the result register loads from the queue whenever it is free or being popped
// throughput: one byte per cycle while the queue has room; the front end is a single-cycle
//   byte walker and the back end does one 16x11 scaling multiply per cycle
// reset: asynchronous, clears frame state, queue and result valid; no clearing pass
module io_sample_frame_parser import isfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte request side
  input  logic              push,
  output logic              full,
  input  logic [7:0]        frame_byte_i,
  input  logic              frame_start_i,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic              kind_o,
  output logic [ChanW-1:0]  channel_o,
  output logic [ValueW-1:0] value_o,
  output logic              last_o
);

  // a byte request is taken whenever the request queue has room; bytes that
  // produce no result never touch the queue
  logic accept;
  logic enq;
  cmd_t enq_cmd;
  logic in_frame;

  // queue to back end
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  logic q_take;

  logic res_valid;

  assign accept = push && !q_full;
  assign full   = q_full;

  // front end: byte position tracking, mask decode, pairing of high/low bytes
  isfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_byte_i  (frame_byte_i),
    .frame_start_i (frame_start_i),
    .enq_o         (enq),
    .cmd_o         (enq_cmd),
    .in_frame_o    (in_frame)
  );

  // decouples the byte walker from a stalled consumer
  isfp_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (enq),
    .wr_cmd_i (enq_cmd),
    .full_o   (q_full),
    .rd_i     (q_take),
    .rd_cmd_o (q_cmd),
    .empty_o  (q_empty)
  );

  // back end: millivolt scaling and the result register
  isfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_take_o  (q_take),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .kind_o      (kind_o),
    .channel_o   (channel_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  assign empty = !res_valid;

`ifndef ASSERT_OFF
  // a request marked last closes the frame
  a_last_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq && enq_cmd.last |=> !in_frame)
    else $error("frame still open after last result");

  // results are only produced from a taken byte inside a frame
  a_enq_needs_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |-> accept && in_frame && !frame_start_i)
    else $error("result produced outside a frame");

  // digital words always report slot zero
  a_digital_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq && enq_cmd.kind == KIND_DIGITAL |-> enq_cmd.channel == '0)
    else $error("digital result with nonzero channel");

  // scaled analog values stay within the millivolt range
  a_analog_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_ANALOG |-> value_o <= ValueW'(MaxMillivolts))
    else $error("analog value out of range");
`endif

endmodule

// ===== bench/tb_io_sample_frame_parser.sv =====
// testbench for the i/o sample frame parser: random frames checked against a built-in predictor
module tb_io_sample_frame_parser;
  import isfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one expected reading as it should leave the result ports
  typedef struct packed {
    kind_e              kind;
    logic [ChanW-1:0]   channel;
    logic [ValueW-1:0]  value;
    logic               last;
  } reading_t;

  // tracks the frame the same way the block does and keeps the readings still owed
  class sample_frame_checker;
    reading_t    owed_readings[$];
    int unsigned mismatches = 0;

    logic       in_frame    = 1'b0;
    logic [4:0] byte_pos    = '0;
    logic       has_digital = 1'b0;
    logic [3:0] analog_bits = '0;
    logic [2:0] analog_slot = '0;
    logic [7:0] held_hi     = '0;

    // walks one accepted byte; returns 1 when the byte took part in a frame
    function bit take_byte(input logic [7:0] b, input logic start);
      int unsigned pos;
      int unsigned base;
      int unsigned enabled;
      logic [15:0] raw;
      reading_t    r;
      if (start) begin
        in_frame    = 1'b1;
        byte_pos    = 5'd1;
        has_digital = 1'b0;
        analog_bits = '0;
        analog_slot = '0;
        held_hi     = '0;
        return 1'b1;
      end
      if (!in_frame) return 1'b0;
      pos      = byte_pos;
      byte_pos = byte_pos + 5'd1;
      enabled  = (analog_bits < MaxAnalog) ? analog_bits : MaxAnalog;
      // two digital mask bytes, then the analog mask
      if (pos == 1 || pos == 2) begin
        if (b != 8'h00) has_digital = 1'b1;
        return 1'b1;
      end
      if (pos == 3) begin
        analog_bits = 4'($countones(b));
        if (!has_digital && analog_bits == 0) in_frame = 1'b0;
        return 1'b1;
      end
      // digital state word, high byte first
      if (has_digital && pos == 4) begin
        held_hi = b;
        return 1'b1;
      end
      if (has_digital && pos == 5) begin
        r.kind    = KIND_DIGITAL;
        r.channel = '0;
        r.value   = {1'b0, held_hi, b};
        r.last    = (enabled == 0);
        owed_readings.push_back(r);
        if (r.last) in_frame = 1'b0;
        return 1'b1;
      end
      base = has_digital ? 6 : 4;
      if (pos < base || analog_slot >= enabled) begin
        in_frame = 1'b0;
        return 1'b1;
      end
      if (((pos - base) & 1) == 0) begin
        held_hi = b;
        return 1'b1;
      end
      raw       = {held_hi, b};
      r.kind    = KIND_ANALOG;
      r.channel = analog_slot[ChanW-1:0];
      r.value   = ValueW'((32'(raw) * MvScale) >> MvShift);
      r.last    = (analog_slot + 1 >= enabled);
      owed_readings.push_back(r);
      analog_slot = analog_slot + 3'd1;
      if (r.last) in_frame = 1'b0;
      return 1'b1;
    endfunction

    // compares one popped result with the oldest owed reading
    function void check_reading(input logic kind, input logic [ChanW-1:0] channel,
                                input logic [ValueW-1:0] value, input logic last);
      reading_t e;
      if (owed_readings.size() == 0) begin
        $error("unexpected result: kind %0d channel %0d value %0d last %0d",
               kind, channel, value, last);
        mismatches++;
        return;
      end
      e = owed_readings.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        mismatches++;
      end
      if (channel !== e.channel) begin
        $error("channel: expected %0d, actual %0d", e.channel, channel);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("value: expected %0d, actual %0d", e.value, value);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [7:0]        frame_byte_i;
  logic              frame_start_i;
  logic              empty;
  logic              pop;
  logic              kind_o;
  logic [ChanW-1:0]  channel_o;
  logic [ValueW-1:0] value_o;
  logic              last_o;

  sample_frame_checker checker_h = new();

  // bytes that took part in a frame, used only to pace the stimulus
  int unsigned frame_bytes_seen = 0;

  // idle and stall odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  io_sample_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .frame_byte_i  (frame_byte_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .channel_o     (channel_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

  // both handshakes are sampled at the edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        frame_bytes_seen += checker_h.take_byte(frame_byte_i, frame_start_i);
      end
      if (pop && !empty) begin
        checker_h.check_reading(kind_o, channel_o, value_o, last_o);
      end
    end
  end

  // one byte request, after a random number of idle cycles
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    frame_byte_i  <= b;
    frame_start_i <= start;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // mostly random bytes, with the all-zero and all-one extremes now and then
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // a well-formed frame with random content, or now and then a cut one,
  // one with trailing junk, or a burst of noise
  task automatic send_random_frame();
    logic [7:0]  body[$];
    logic [7:0]  dmask_hi;
    logic [7:0]  dmask_lo;
    logic [7:0]  amask;
    int unsigned shape;
    int unsigned n_analog;
    int unsigned r;
    shape = $urandom_range(99);
    if (shape < 8) begin
      // noise, with a stray start now and then
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    body.push_back(8'($urandom));
    r = $urandom_range(3);
    dmask_hi = (r == 1 || r == 3) ? pick_byte() : 8'h00;
    dmask_lo = (r == 2 || r == 3) ? pick_byte() : 8'h00;
    r = $urandom_range(7);
    amask = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
    body.push_back(dmask_hi);
    body.push_back(dmask_lo);
    body.push_back(amask);
    if ((dmask_hi | dmask_lo) != 8'h00) begin
      body.push_back(pick_byte());
      body.push_back(pick_byte());
    end
    n_analog = $countones(amask);
    if (n_analog > MaxAnalog) n_analog = MaxAnalog;
    repeat (n_analog) begin
      body.push_back(pick_byte());
      body.push_back(pick_byte());
    end
    // cut frame: the next start drops it
    if (shape < 20 && body.size() > 1) begin
      r = $urandom_range(1, body.size() - 1);
      while (body.size() > r) void'(body.pop_back());
    end
    // bytes after the end of the frame are ignored
    if (shape >= 20 && shape < 28) begin
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    end
    foreach (body[i]) send_byte(body[i], i == 0);
  endtask

  // holds the sender back until every owed reading has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (checker_h.owed_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n_bytes);
    int unsigned stop_at;
    send_idle_pct = idle;
    pop_stall_pct = stall;
    stop_at = frame_bytes_seen + n_bytes;
    while (frame_bytes_seen < stop_at) send_random_frame();
  endtask

  // result side: pop held high or low per cycle at the phase's stall odds
  task automatic drain_results();
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  endtask

  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    drain_results();
  end

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    frame_byte_i  <= '0;
    frame_start_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling on either side
    // byte with no frame open is ignored
    send_byte(8'hff, 1'b0);
    // empty masks: frame ends after the analog mask, nothing comes out
    send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // digital only: one word, marked last
    send_byte(8'h80, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
    // start inside a frame drops the old one
    send_byte(8'h01, 1'b1); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
    // all eight analog bits: only the first readings up to the limit come out
    send_byte(8'h7f, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'hab, 1'b0); send_byte(8'hcd, 1'b0);
    // ignored once the frame has ended
    send_byte(8'h55, 1'b0);
    wait_drained();

    // random part, one phase per idling mix, each drained before the next
    run_phase(0, 0, 130);
    wait_drained();
    run_phase(63, 0, 130);
    wait_drained();
    run_phase(0, 63, 130);
    wait_drained();
    run_phase(18, 18, 130);
    wait_drained();

    // keep the clock running to catch any stray result
    repeat (12) @(posedge clk_i);
    if (checker_h.mismatches == 0 && checker_h.owed_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
